// File: hw/rtl/lwir_pkg.sv
// Shared types and constants for the log-weight importance resampler.
// No dependencies.
package lwir_pkg;

   localparam int FUNC_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int RAND_W   = 24;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;
   localparam int CSR_ADDR_W = 1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_DRAW  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   localparam logic [CSR_ADDR_W-1:0] REG_WEIGHT_MODE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_LOG_SCALE   = 1'b1;

   localparam logic [16:0] LOG2E_Q16 = 17'd94548;

   // round(65536*ln(1+exp(-k/2))), zero from k = 24 on
   function automatic logic [15:0] corr_lookup(input logic [4:0] k);
      logic [15:0] c;
      case (k)
         5'd0:  c = 16'd45426;
         5'd1:  c = 16'd31069;
         5'd2:  c = 16'd20530;
         5'd3:  c = 16'd13200;
         5'd4:  c = 16'd8318;
         5'd5:  c = 16'd5170;
         5'd6:  c = 16'd3184;
         5'd7:  c = 16'd1950;
         5'd8:  c = 16'd1189;
         5'd9:  c = 16'd724;
         5'd10: c = 16'd440;
         5'd11: c = 16'd267;
         5'd12: c = 16'd162;
         5'd13: c = 16'd98;
         5'd14: c = 16'd60;
         5'd15: c = 16'd36;
         5'd16: c = 16'd22;
         5'd17: c = 16'd13;
         5'd18: c = 16'd8;
         5'd19: c = 16'd5;
         5'd20: c = 16'd3;
         5'd21: c = 16'd2;
         5'd22: c = 16'd1;
         5'd23: c = 16'd1;
         default: c = 16'd0;
      endcase
      return c;
   endfunction

   // 2^(-j/16) in Q1.24
   function automatic logic [24:0] pow2_lookup(input logic [4:0] j);
      logic [24:0] p;
      case (j)
         5'd0:  p = 25'd16777216;
         5'd1:  p = 25'd16065917;
         5'd2:  p = 25'd15384775;
         5'd3:  p = 25'd14732511;
         5'd4:  p = 25'd14107901;
         5'd5:  p = 25'd13509772;
         5'd6:  p = 25'd12937002;
         5'd7:  p = 25'd12388516;
         5'd8:  p = 25'd11863283;
         5'd9:  p = 25'd11360319;
         5'd10: p = 25'd10878679;
         5'd11: p = 25'd10417458;
         5'd12: p = 25'd9975792;
         5'd13: p = 25'd9552851;
         5'd14: p = 25'd9147842;
         5'd15: p = 25'd8760004;
         default: p = 25'd8388608;
      endcase
      return p;
   endfunction

endpackage

// File: hw/rtl/lwir_if.sv
// Valid/ready channel interfaces for the resampler.
// Depends on lwir_pkg.
interface lwir_req_if;
   import lwir_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic signed [VALUE_W-1:0] sample_value;
   logic [RAND_W-1:0]     random_fraction;
   modport source (output valid, func, sample_value, random_fraction, input ready);
   modport sink   (input valid, func, sample_value, random_fraction, output ready);
endinterface

interface lwir_rsp_if;
   import lwir_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [INDEX_W-1:0]    selected_index;
   logic [STATUS_W-1:0]   status;
   modport source (output valid, selected_index, status, input ready);
   modport sink   (input valid, selected_index, status, output ready);
endinterface

interface lwir_csr_if;
   import lwir_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [VALUE_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/lwir_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lwir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hw/rtl/log_weight_importance_resampler.sv
// Top level of the log-weight importance resampler.
// Depends on lwir_pkg, lwir_if and lwir_ram.
//
// Items are taken one at a time. Clear and unused codes go straight to done.
// A load does only the log-add in weight mode 0, more in mode 1 (multiply, then
// log-add with saturation; the cumulative value is written to the store).
// A draw runs a binary search over the cumulative-log store: each probe is
// one RAM read plus a three-stage exponential, and a draw makes at most
// ceil(log2(count+1)) probes. The result is held in an output register,
// and the next item is taken while it waits.
// The store needs no clearing after reset: only loaded entries are read.
module log_weight_importance_resampler #(
   parameter int MAX_SAMPLES = 1024,
   parameter int RANDOM_BITS = 24
) (
   input logic clock,
   input logic reset,
   lwir_req_if.sink   req,
   lwir_rsp_if.source rsp,
   lwir_csr_if.sink   csr
);
   import lwir_pkg::*;

   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_MULSAT, ST_ADD, ST_WRITE,
      ST_PROBE, ST_READ, ST_EXP0, ST_EXP1, ST_EXP2, ST_DONE
   } state_type;

   state_type                 state_ff;
   logic                      mode_ff;
   logic signed [31:0]        scale_ff;
   logic [CNT_W-1:0]          count_ff;
   logic signed [31:0]        total_ff;
   logic signed [31:0]        value_ff;
   logic signed [63:0]        prod_ff;
   logic signed [31:0]        cum_ff;
   logic [23:0]               frac_ff;
   logic [CNT_W-1:0]          lo_ff, hi_ff;
   logic [CNT_W-1:0]          mid_ff;
   logic [21:0]               t_hi_ff;
   logic [5:0]                y_n_ff;
   logic [24:0]               base_ff;
   logic [INDEX_W-1:0]        res_index_ff;
   status_type                res_status_ff;
   logic                      rsp_valid_ff;
   logic [INDEX_W-1:0]        rsp_index_ff;
   status_type                rsp_status_ff;

   // Store
   logic                      wr_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic [31:0]               rd_data;

   lwir_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (cum_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_en   = (state_ff == ST_WRITE);
   assign rd_addr = mid_ff[ADDR_W-1:0];

   // Handshakes
   logic rsp_load;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.selected_index = rsp_index_ff;
   assign rsp.status = rsp_status_ff;

   // Scale raw fraction to Q0.24
   logic [23:0] frac_in;
   always_comb begin
      if (RANDOM_BITS >= 24) begin
         frac_in = req.random_fraction >> (RANDOM_BITS - 24);
      end else begin
         frac_in = req.random_fraction << (24 - RANDOM_BITS);
      end
   end

   // Energy product, floor shift, saturate
   logic signed [47:0] prod_sh;
   logic signed [31:0] scaled_sat;
   assign prod_sh = 48'(prod_ff >>> 16);
   always_comb begin
      if (prod_sh > 48'sd2147483647)       scaled_sat = 32'sh7fffffff;
      else if (prod_sh < -48'sd2147483648) scaled_sat = 32'sh80000000;
      else                                 scaled_sat = prod_sh[31:0];
   end

   // Log-add of running total and new value
   logic signed [32:0] la_diff;
   logic [32:0]        la_abs;
   logic [33:0]        la_k;
   logic [15:0]        la_corr;
   logic signed [31:0] la_max;
   logic signed [33:0] la_sum;
   logic signed [31:0] la_res;
   always_comb begin
      la_diff = 33'(total_ff) - 33'(value_ff);
      la_abs  = la_diff[32] ? 33'(-la_diff) : la_diff;
      la_k    = (34'(la_abs) + 34'd16384) >> 15;
      la_corr = (la_k < 34'd24) ? corr_lookup(la_k[4:0]) : 16'd0;
      la_max  = (total_ff > value_ff) ? total_ff : value_ff;
      la_sum  = 34'(la_max) + 34'(la_corr);
      if (la_sum > 34'sd2147483647) la_res = 32'sh7fffffff;
      else                          la_res = la_sum[31:0];
   end

   // Exponential stage 0: clamp y, multiply by log2(e)
   logic signed [32:0] y_raw;
   logic [21:0]        y_cl;
   logic [37:0]        t_full;
   always_comb begin
      y_raw = 33'(total_ff) - 33'($signed(rd_data));
      if (y_raw < 0)                y_cl = 22'd0;
      else if (y_raw > 33'sd2097152) y_cl = 22'd2097152;
      else                          y_cl = y_raw[21:0];
      t_full = 38'(y_cl) * 38'(LOG2E_Q16);
   end

   // Exponential stage 1: table interpolation
   logic [15:0] ex_f;
   logic [4:0]  ex_j;
   logic [24:0] ex_p0, ex_p1;
   logic [36:0] ex_dl;
   always_comb begin
      ex_f  = t_hi_ff[15:0];
      ex_j  = {1'b0, ex_f[15:12]};
      ex_p0 = pow2_lookup(ex_j);
      ex_p1 = pow2_lookup(ex_j + 5'd1);
      ex_dl = 37'(ex_p0 - ex_p1) * 37'(ex_f[11:0]);
   end

   // Exponential stage 2: shift by integer part, compare
   logic [24:0] weight;
   logic        go_right;
   assign weight   = (y_n_ff > 6'd24) ? 25'd0 : (base_ff >> y_n_ff);
   assign go_right = weight < {1'b0, frac_ff};

   logic [CNT_W-1:0] lo_next, hi_next;
   assign lo_next = go_right ? mid_ff + CNT_W'(1) : lo_ff;
   assign hi_next = go_right ? hi_ff : mid_ff;

   // Registers: configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         scale_ff <= '0;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            REG_WEIGHT_MODE: mode_ff  <= csr.data[0];
            REG_LOG_SCALE:   scale_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // Control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         total_ff      <= '0;
         res_index_ff  <= '0;
         res_status_ff <= STATUS_OK;
         rsp_valid_ff  <= 1'b0;
         rsp_index_ff  <= '0;
         rsp_status_ff <= STATUS_OK;
      end else begin
         // output register: load a finished item, or drop the taken beat
         if (rsp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_index_ff  <= res_index_ff;
            rsp_status_ff <= res_status_ff;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  value_ff <= req.sample_value;
                  frac_ff  <= frac_in;
                  lo_ff    <= '0;
                  hi_ff    <= count_ff;
                  res_index_ff  <= '0;
                  res_status_ff <= STATUS_OK;
                  case (func_type'(req.func))
                     FUNC_CLEAR: begin
                        count_ff <= '0;
                        total_ff <= '0;
                        state_ff <= ST_DONE;
                     end
                     FUNC_LOAD: begin
                        if (count_ff >= MAX_CNT) begin
                           res_status_ff <= STATUS_FULL;
                           state_ff      <= ST_DONE;
                        end else begin
                           state_ff <= mode_ff ? ST_MUL : ST_ADD;
                        end
                     end
                     FUNC_DRAW: begin
                        if (count_ff == '0) begin
                           res_status_ff <= STATUS_EMPTY;
                           state_ff      <= ST_DONE;
                        end else begin
                           state_ff <= ST_PROBE;
                        end
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_MUL: begin
               prod_ff  <= 64'(value_ff) * 64'(scale_ff);
               state_ff <= ST_MULSAT;
            end
            ST_MULSAT: begin
               value_ff <= scaled_sat;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               cum_ff   <= (count_ff == '0) ? value_ff : la_res;
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               total_ff <= cum_ff;
               count_ff <= count_ff + CNT_W'(1);
               state_ff <= ST_DONE;
            end
            ST_PROBE: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= lo_ff + ((hi_ff - lo_ff) >> 1);
                  state_ff <= ST_READ;
               end else begin
                  res_index_ff <= INDEX_W'((lo_ff >= count_ff) ?
                                           count_ff - CNT_W'(1) : lo_ff);
                  state_ff     <= ST_DONE;
               end
            end
            ST_READ: state_ff <= ST_EXP0;
            ST_EXP0: begin
               t_hi_ff  <= t_full[37:16];
               state_ff <= ST_EXP1;
            end
            ST_EXP1: begin
               y_n_ff   <= t_hi_ff[21:16];
               base_ff  <= ex_p0 - 25'(ex_dl >> 12);
               state_ff <= ST_EXP2;
            end
            ST_EXP2: begin
               lo_ff    <= lo_next;
               hi_ff    <= hi_next;
               state_ff <= ST_PROBE;
            end
            ST_DONE: begin
               // wait here while the previous beat is still held
               if (rsp_load) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("sample count beyond store depth");
   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> count_ff < MAX_CNT) else $error("store write when full");
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("ready while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff) else $error("result not raised");

endmodule

// File: dv/lwir_checker.sv
// Result checker for the log-weight importance resampler: watches the request,
// response and register-write channels, predicts each response and compares.
// Depends on lwir_pkg and lwir_if.
`timescale 1ns / 1ps
module lwir_checker #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   lwir_req_if        req,
   lwir_rsp_if        rsp,
   lwir_csr_if        csr,
   output int         error_count,
   output int         pending_count
);
   import lwir_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      status_type         status;
   } pick_type;

   logic signed [31:0] cum_log [MAX_SAMPLES];
   int unsigned        count;
   logic signed [31:0] log_total;
   logic               mode;
   logic signed [31:0] scale;
   pick_type           expected_picks[$];

   localparam logic [31:0] CORR [24] = '{45426, 31069, 20530, 13200, 8318, 5170, 3184,
      1950, 1189, 724, 440, 267, 162, 98, 60, 36, 22, 13, 8, 5, 3, 2, 1, 1};
   localparam logic [31:0] POW2 [17] = '{16777216, 16065917, 15384775, 14732511,
      14107901, 13509772, 12937002, 12388516, 11863283, 11360319, 10878679,
      10417458, 9975792, 9552851, 9147842, 8760004, 8388608};

   function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // energy times scale, floor shift by 16
   function automatic logic signed [31:0] tempered(logic signed [31:0] e);
      longint p;
      p = longint'(e) * longint'(scale);
      return clip32(p >>> 16);
   endfunction

   function automatic logic signed [31:0] log_sum(logic signed [31:0] a,
                                                  logic signed [31:0] b);
      longint m, d, k;
      m = (a > b) ? a : b;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      k = (d + 16384) >>> 15;
      return clip32(m + ((k < 24) ? longint'(CORR[k]) : 0));
   endfunction

   // normalised weight exp(-y), Q1.24
   function automatic longint weight_of(int unsigned i);
      longint y, t, n, f, j, r, b;
      y = longint'(log_total) - longint'(cum_log[i]);
      if (y < 0) y = 0;
      if (y > (longint'(32) << 16)) y = longint'(32) << 16;
      t = (y * 94548) >>> 16;
      n = t >>> 16;
      f = t & 16'hffff;
      if (n > 24) return 0;
      j = f >>> 12;
      r = f & 12'hfff;
      b = POW2[j] - (((POW2[j] - POW2[j+1]) * r) >>> 12);
      return b >>> n;
   endfunction

   function automatic pick_type resample(logic [1:0] fn, logic signed [31:0] v,
                                         logic [23:0] u);
      pick_type p;
      int unsigned lo, hi, mid;
      logic signed [31:0] w;
      p = '{index: '0, status: STATUS_OK};
      case (func_type'(fn))
         FUNC_CLEAR: begin
            count = 0;
            log_total = 0;
         end
         FUNC_LOAD: begin
            if (count >= MAX_SAMPLES) p.status = STATUS_FULL;
            else begin
               w = mode ? tempered(v) : v;
               w = (count == 0) ? w : log_sum(log_total, w);
               cum_log[count] = w;
               log_total = w;
               count++;
            end
         end
         FUNC_DRAW: begin
            if (count == 0) p.status = STATUS_EMPTY;
            else begin
               lo = 0;
               hi = count;
               while (lo < hi) begin
                  mid = lo + ((hi - lo) >> 1);
                  if (weight_of(mid) < longint'(u)) lo = mid + 1;
                  else hi = mid;
               end
               if (lo >= count) lo = count - 1;
               p.index = lo[INDEX_W-1:0];
            end
         end
         default: ;
      endcase
      return p;
   endfunction

   assign pending_count = expected_picks.size();

   always @(posedge clock) begin
      pick_type want;
      if (reset) begin
         count = 0;
         log_total = 0;
         mode = 1'b0;
         scale = 0;
         error_count <= 0;
         expected_picks.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == REG_WEIGHT_MODE) mode = csr.data[0];
            else if (csr.index == REG_LOG_SCALE) scale = csr.data;
         end
         if (req.valid && req.ready)
            expected_picks.push_back(resample(req.func, req.sample_value,
                                              req.random_fraction));
         if (rsp.valid && rsp.ready) begin
            if (expected_picks.size() == 0) begin
               $display("%0t: unexpected response index %0d status %0d", $time,
                        rsp.selected_index, rsp.status);
               error_count <= error_count + 1;
            end else begin
               want = expected_picks.pop_front();
               if (rsp.selected_index !== want.index || rsp.status !== want.status) begin
                  $display("%0t: mismatch expected index %0d status %0d, actual %0d/%0d",
                           $time, want.index, want.status, rsp.selected_index,
                           rsp.status);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: dv/log_weight_importance_resampler_tb.sv
// Testbench top for the log-weight importance resampler: clock, reset,
// stimulus and verdict. Depends on lwir_pkg, lwir_if and lwir_checker.
`timescale 1ns / 1ps
module log_weight_importance_resampler_tb;
   import lwir_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count, pending_count;

   lwir_req_if req ();
   lwir_rsp_if rsp ();
   lwir_csr_if csr ();

   log_weight_importance_resampler u_top (.clock, .reset, .req, .rsp, .csr);
   lwir_checker u_check (.clock, .reset, .req, .rsp, .csr, .error_count, .pending_count);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver stall pattern, with quiet stretches of no stalling
   initial begin
      int stall_pct;
      rsp.ready = 1'b0;
      stall_pct = 0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) == 0) stall_pct = $urandom_range(0, 3) * 25;
         rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [31:0] d);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= d;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
   endtask

   int burst_left = 0;

   // valid stays high across a burst; it drops only at the start of a gap
   task automatic send(func_type fn, logic [31:0] v, logic [23:0] u);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req.valid <= 1'b1;
      req.func <= fn;
      req.sample_value <= v;
      req.random_fraction <= u;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   initial begin
      int n;
      req.valid = 1'b0;
      req.func = FUNC_CLEAR;
      req.sample_value = '0;
      req.random_fraction = '0;
      csr.valid = 1'b0;
      csr.index = REG_WEIGHT_MODE;
      csr.data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty draw, extremes, unused code, clear, small loads and draws
      send(FUNC_DRAW, 0, 24'hffffff);
      send(FUNC_LOAD, 32'h80000000, 0);
      send(FUNC_LOAD, 32'h7fffffff, 0);
      send(FUNC_LOAD, 32'h7fffffff, 0);
      send(FUNC_DRAW, 0, 24'hffffff);
      send(FUNC_DRAW, 0, 0);
      send(FUNC_NONE, 32'hffffffff, 24'hffffff);
      send(FUNC_CLEAR, 0, 0);
      send(FUNC_LOAD, 32'h00010000, 0);
      send(FUNC_LOAD, 32'hfff00000, 0);
      send(FUNC_LOAD, 32'h00020000, 0);
      send(FUNC_DRAW, 0, 24'h800000);
      send(FUNC_DRAW, 0, 24'h000001);
      drain();

      // energy mode at extreme scales
      write_reg(REG_WEIGHT_MODE, 1);
      write_reg(REG_LOG_SCALE, 32'h80000000);
      send(FUNC_CLEAR, 0, 0);
      send(FUNC_LOAD, 32'h7fffffff, 0);
      send(FUNC_LOAD, 32'h80000000, 0);
      send(FUNC_DRAW, 0, 24'h555555);
      drain();
      write_reg(REG_LOG_SCALE, 32'h7fffffff);
      send(FUNC_LOAD, 32'h80000000, 0);
      send(FUNC_LOAD, 32'h00008000, 0);
      send(FUNC_DRAW, 0, 24'haaaaaa);
      drain();

      // random phases: mostly small sets, random mix of loads, draws, clears and unused codes
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_WEIGHT_MODE, 32'(ph[0]));
         write_reg(REG_LOG_SCALE, (ph == 5) ? 32'h00010000 : $urandom());
         n = 0;
         while (n < 120) begin
            case ($urandom_range(0, 19))
               0: send(FUNC_CLEAR, $urandom(), 24'($urandom()));
               1: send(FUNC_NONE, $urandom(), 24'($urandom()));
               2, 3, 4, 5, 6, 7, 8: send(FUNC_LOAD, rand_value(), 24'($urandom()));
               default: send(FUNC_DRAW, $urandom(), 24'($urandom()));
            endcase
            n++;
            if (n == 60 && ph == 2) drain();
         end
         drain();
      end

      if (error_count == 0)
         $display("log_weight_importance_resampler_tb: PASS");
      else
         $display("log_weight_importance_resampler_tb: FAIL");
      $finish;
   end

   initial begin
      #(8 * 400000);
      $display("log_weight_importance_resampler_tb: FAIL");
      $finish;
   end

endmodule
